/* design/grr_pkg.sv */
package grr_pkg;

  localparam int NODE_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int OPCODE_W  = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_CONNECT    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DISCONNECT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 2'd2;

  localparam logic [COUNT_W-1:0] MIN_NODE_COUNT = 7'd2;

endpackage

/* design/grr_row_mem.sv */
module grr_row_mem #(
  parameter int MAX_NODES = 64,
  localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [MAX_NODES-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [MAX_NODES-1:0] wr_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid_r;
  logic [MAX_NODES-1:0] rd_q_r;
  logic                 rd_vld_r;

  // a row never written since reset reads as no edges
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

/* design/grr_seq.sv */
module grr_seq #(
  parameter int MAX_NODES = 64,
  localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [grr_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [grr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic [grr_pkg::COUNT_W-1:0]       node_count,
  input  logic [MAX_NODES-1:0]              col_mask,
  output logic                              mem_rd_en,
  output logic [AW-1:0]                     mem_rd_addr,
  input  logic [MAX_NODES-1:0]              mem_rd_data,
  output logic                              mem_wr_en,
  output logic [AW-1:0]                     mem_wr_addr,
  output logic [MAX_NODES-1:0]              mem_wr_data
);
  import grr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EDIT  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_NODES);
  localparam logic [MAX_NODES-1:0] ONE_HOT0 = MAX_NODES'(1);

  logic [1:0]           state_r, state_nxt;
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [NODE_W-1:0]    src_r, src_nxt;
  logic [NODE_W-1:0]    dst_r, dst_nxt;
  logic                 edit_ok_r, edit_ok_nxt;
  logic [MAX_NODES-1:0] mask_r, mask_nxt;
  logic [COUNT_W-1:0]   sweeps_r, sweeps_nxt;
  logic                 changed_r, changed_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [COUNT_W-1:0]   emit_r, emit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]    out_node_r, out_node_nxt;
  logic                 out_energ_r, out_energ_nxt;
  logic [COUNT_W-1:0]   out_sweeps_r, out_sweeps_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [OPCODE_W-1:0]  in_op;
  logic [NODE_W-1:0]    in_src;
  logic [NODE_W-1:0]    in_dst;
  logic                 in_xfer;
  logic [COUNT_W-1:0]   last_node;
  logic [MAX_NODES-1:0] fresh;
  logic [MAX_NODES-1:0] edge_bit;
  logic                 row_end;
  logic                 out_load;

  assign in_op  = in_tdata[OPCODE_W-1:0];
  assign in_src = in_tdata[OPCODE_W +: NODE_W];
  assign in_dst = in_tdata[OPCODE_W+NODE_W +: NODE_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign last_node = node_count - COUNT_W'(1);

  // row unit: targets of an energized source that are not yet energized
  assign fresh    = mask_r[row_r] ? (mem_rd_data & col_mask & ~mask_r) : '0;
  assign row_end  = ({{(COUNT_W-AW){1'b0}}, row_r} == last_node);
  assign edge_bit = ONE_HOT0 << dst_r[AW-1:0];
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    edit_ok_nxt    = edit_ok_r;
    mask_nxt       = mask_r;
    sweeps_nxt     = sweeps_r;
    changed_nxt    = changed_r;
    row_nxt        = row_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_node_nxt   = out_node_r;
    out_energ_nxt  = out_energ_r;
    out_sweeps_nxt = out_sweeps_r;
    out_last_nxt   = out_last_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = AW'(1);
    mem_wr_en      = 1'b0;
    mem_wr_addr    = src_r[AW-1:0];
    mem_wr_data    = (op_r == OP_CONNECT) ? (mem_rd_data | edge_bit)
                                          : (mem_rd_data & ~edge_bit);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt      = in_op;
          src_nxt     = in_src;
          dst_nxt     = in_dst;
          edit_ok_nxt = ({1'b0, in_src} < MAX_N) && ({1'b0, in_dst} < MAX_N);
          if (in_op == OP_CONNECT || in_op == OP_DISCONNECT) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = in_src[AW-1:0];
            state_nxt   = S_EDIT;
          end else if (in_op == OP_QUERY) begin
            mask_nxt    = ONE_HOT0 << 1;
            sweeps_nxt  = COUNT_W'(1);
            changed_nxt = 1'b0;
            row_nxt     = AW'(1);
            mem_rd_en   = 1'b1;
            state_nxt   = S_SWEEP;
          end
        end
      end
      S_EDIT: begin
        mem_wr_en = edit_ok_r;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        mask_nxt = mask_r | fresh;
        if (row_end) begin
          if (changed_r || (fresh != '0)) begin
            // start another sweep from row 1
            sweeps_nxt  = sweeps_r + COUNT_W'(1);
            changed_nxt = 1'b0;
            row_nxt     = AW'(1);
            mem_rd_en   = 1'b1;
          end else begin
            emit_nxt  = COUNT_W'(1);
            state_nxt = S_EMIT;
          end
        end else begin
          changed_nxt = changed_r || (fresh != '0);
          row_nxt     = row_r + AW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = row_r + AW'(1);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = emit_r[NODE_W-1:0];
          out_energ_nxt  = mask_r[emit_r[AW-1:0]];
          out_sweeps_nxt = sweeps_r;
          out_last_nxt   = (emit_r == last_node);
          emit_nxt       = emit_r + COUNT_W'(1);
          if (emit_r == last_node) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    edit_ok_r    <= edit_ok_nxt;
    mask_r       <= mask_nxt;
    sweeps_r     <= sweeps_nxt;
    changed_r    <= changed_nxt;
    row_r        <= row_nxt;
    emit_r       <= emit_nxt;
    out_node_r   <= out_node_nxt;
    out_energ_r  <= out_energ_nxt;
    out_sweeps_r <= out_sweeps_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-NODE_W-1-COUNT_W){1'b0}},
                       out_sweeps_r, out_energ_r, out_node_r};

endmodule

/* design/graph_reachability_from_source.sv */
// Reachability from node 1 over a directed adjacency bit matrix held in an internal
// row memory (rows read empty after reset). An edge connect or disconnect reads the row,
// then writes it, so in_tready drops for one cycle after the transfer. A query energizes
// node 1 and sweeps rows 1..node_count-1, one row per cycle through a single row-update
// unit, until a sweep adds no node. It then loads node_count-1 results into the output
// register, one per cycle when out_tready stays high, and takes the next item once the
// last result sits in the output register, so in_tready stays low through the sweeps
// and the loads.
// node_count is clamped to 2..MAX_NODES and must only be written while the block is idle.
module graph_reachability_from_source #(
  parameter int MAX_NODES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [grr_pkg::COUNT_W-1:0]     cfg_wdata,   // node_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [grr_pkg::IN_DATA_W-1:0]   in_tdata,    // opcode, from_node, to_node, pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [grr_pkg::OUT_DATA_W-1:0]  out_tdata,   // node_index, energized, sweep_count, pad
  output logic                            out_tlast
);
  import grr_pkg::*;

  localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_NODES);

  logic [COUNT_W-1:0]   node_count_r, node_count_nxt;
  logic [MAX_NODES-1:0] col_mask_r, col_mask_nxt;

  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [MAX_NODES-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [MAX_NODES-1:0] mem_wr_data;

  // clamp the node count and keep the matching column mask
  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_we) begin
      if (cfg_wdata < MIN_NODE_COUNT) begin
        node_count_nxt = MIN_NODE_COUNT;
      end else if (cfg_wdata > MAX_N) begin
        node_count_nxt = MAX_N;
      end else begin
        node_count_nxt = cfg_wdata;
      end
    end
    for (int j = 0; j < MAX_NODES; j++) begin
      col_mask_nxt[j] = (COUNT_W'(j) < node_count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= MAX_N;
      col_mask_r   <= '1;
    end else begin
      node_count_r <= node_count_nxt;
      col_mask_r   <= col_mask_nxt;
    end
  end

  grr_row_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  grr_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .node_count  (node_count_r),
    .col_mask    (col_mask_r),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

/* bench/graph_reachability_from_source_tb.sv */
`timescale 1ns / 100ps

module graph_reachability_from_source_tb;
  import grr_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int NODES = 64;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic               energized;
    logic [COUNT_W-1:0] sweeps;
    logic               last;
  } node_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [COUNT_W-1:0]    cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // opcode, from_node, to_node, pad
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // node_index, energized, sweep_count, pad
  logic                  out_tlast;

  // graph model
  logic [NODES-1:0]   edge_rows [NODES];
  logic [COUNT_W-1:0] node_count_model;
  node_report_t       node_report_q [$];

  bit          idle_on;
  int unsigned out_hold_cycles;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned queries_sent;
  int unsigned reports_checked;
  int unsigned deepest_sweeps;

  graph_reachability_from_source DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic run_reachability();
    logic [NODES-1:0] cols;
    logic [NODES-1:0] lit;
    logic [NODES-1:0] fresh;
    int unsigned      sweeps;
    int               n;
    bit               changed;
    node_report_t     rpt;
    n = int'(node_count_model);
    cols = (n >= NODES) ? '1 : ((64'd1 << n) - 64'd1);
    lit = 64'd2;
    sweeps = 0;
    do begin
      changed = 1'b0;
      sweeps++;
      // in-place sweep: a node lit here is seen by higher rows in the same pass
      for (int i = 1; i < n; i++) begin
        if (lit[i]) begin
          fresh = edge_rows[i] & cols & ~lit;
          if (fresh != '0) begin
            lit |= fresh;
            changed = 1'b1;
          end
        end
      end
    end while (changed);
    if (sweeps > deepest_sweeps) deepest_sweeps = sweeps;
    for (int i = 1; i < n; i++) begin
      rpt.node = i[NODE_W-1:0];
      rpt.energized = lit[i];
      rpt.sweeps = sweeps[COUNT_W-1:0];
      rpt.last = (i == n - 1);
      node_report_q.push_back(rpt);
    end
  endtask

  task automatic update_graph(input logic [OPCODE_W-1:0] op, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst);
    case (op)
      OP_CONNECT:    edge_rows[src][dst] = 1'b1;
      OP_DISCONNECT: edge_rows[src][dst] = 1'b0;
      OP_QUERY: begin
        queries_sent++;
        run_reachability();
      end
      default: ;
    endcase
  endtask

  task automatic send_graph_op(input logic [OPCODE_W-1:0] op, input logic [NODE_W-1:0] src,
                               input logic [NODE_W-1:0] dst);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, dst, src, op};
    do @(posedge clk); while (!in_tready);
    update_graph(op, src, dst);
    items_sent++;
  endtask

  // wait for every report, then give a trailing edge edit time to retire
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (node_report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [COUNT_W-1:0] value);
    drain_block();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value < MIN_NODE_COUNT) node_count_model = MIN_NODE_COUNT;
    else if (value > NODES) node_count_model = COUNT_W'(NODES);
    else node_count_model = value;
  endtask

  task automatic test_reset_state();
    idle_on = 1'b1;
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
  endtask

  task automatic test_directed_edges();
    set_node_count(7'd8);
    send_graph_op(OP_CONNECT, 6'd1, 6'd2);
    send_graph_op(OP_CONNECT, 6'd2, 6'd5);
    // lower target than its source: needs a second sweep
    send_graph_op(OP_CONNECT, 6'd5, 6'd3);
    send_graph_op(OP_CONNECT, 6'd3, 6'd3);
    send_graph_op(OP_CONNECT, 6'd3, 6'd0);
    send_graph_op(OP_CONNECT, 6'd0, 6'd6);
    send_graph_op(OP_CONNECT, 6'd5, 6'd9);
    send_graph_op(OP_UNUSED, 6'd1, 6'd7);
    send_graph_op(OP_UNUSED, 6'd63, 6'd63);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    send_graph_op(OP_DISCONNECT, 6'd2, 6'd5);
    send_graph_op(OP_QUERY, 6'd63, 6'd63);
    send_graph_op(OP_CONNECT, 6'd63, 6'd63);
    send_graph_op(OP_CONNECT, 6'd0, 6'd0);
    send_graph_op(OP_DISCONNECT, 6'd63, 6'd63);
    send_graph_op(OP_CONNECT, 6'd2, 6'd5);
    set_node_count(7'd10);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
  endtask

  task automatic test_node_count_limits();
    idle_on = 1'b0;
    set_node_count(7'd0);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    set_node_count(7'd1);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    set_node_count(7'd127);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    set_node_count(7'd65);
    set_node_count(7'd2);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    set_node_count(7'd64);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
  endtask

  task automatic test_random_graphs();
    int unsigned      roll;
    int unsigned      n;
    int unsigned      hops;
    logic [NODE_W-1:0] path [$];
    logic [NODE_W-1:0] prev;
    logic [NODE_W-1:0] next;
    for (int round = 0; round < 9; round++) begin
      idle_on = (round % 3 != 2);
      roll = $urandom_range(0, 99);
      if (roll < 65) n = $urandom_range(2, 12);
      else if (roll < 85) n = $urandom_range(13, 40);
      else if (roll < 93) n = 64;
      else n = $urandom_range(65, 127);
      set_node_count(n[COUNT_W-1:0]);
      n = 32'(node_count_model);
      // path from node 1 through random nodes, then some scattered edits
      path.delete();
      prev = 6'd1;
      hops = $urandom_range(1, 6);
      for (int h = 0; h < hops; h++) begin
        next = NODE_W'($urandom_range(0, n - 1));
        send_graph_op(OP_CONNECT, prev, next);
        path.push_back(prev);
        path.push_back(next);
        prev = next;
      end
      repeat ($urandom_range(0, 4)) begin
        roll = $urandom_range(0, 99);
        if (roll < 50)
          send_graph_op(OP_CONNECT, NODE_W'($urandom_range(0, n - 1)),
                        NODE_W'($urandom_range(0, n - 1)));
        else if (roll < 75)
          send_graph_op(OP_DISCONNECT, NODE_W'($urandom_range(0, n - 1)),
                        NODE_W'($urandom_range(0, n - 1)));
        else
          send_graph_op(OPCODE_W'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 63)),
                        NODE_W'($urandom_range(0, 63)));
      end
      send_graph_op(OP_QUERY, NODE_W'($urandom_range(0, 63)), NODE_W'($urandom_range(0, 63)));
      // tear the path down so later rounds start sparse
      while (path.size() != 0) begin
        prev = path.pop_front();
        next = path.pop_front();
        if ($urandom_range(0, 3) != 0) send_graph_op(OP_DISCONNECT, prev, next);
      end
    end
  endtask

  task automatic test_descending_chain();
    logic [NODE_W-1:0] chain_src [62];
    logic [NODE_W-1:0] chain_dst [62];
    logic [NODE_W-1:0] swap_src;
    logic [NODE_W-1:0] swap_dst;
    int unsigned       pick;
    idle_on = 1'b1;
    set_node_count(7'd64);
    // 1 -> 63 -> 62 -> ... -> 2: one new node per sweep after the first
    chain_src[0] = 6'd1;
    chain_dst[0] = 6'd63;
    for (int k = 1; k < 62; k++) begin
      chain_src[k] = NODE_W'(64 - k);
      chain_dst[k] = NODE_W'(63 - k);
    end
    for (int k = 61; k > 0; k--) begin
      pick = $urandom_range(0, k);
      swap_src = chain_src[k];
      swap_dst = chain_dst[k];
      chain_src[k] = chain_src[pick];
      chain_dst[k] = chain_dst[pick];
      chain_src[pick] = swap_src;
      chain_dst[pick] = swap_dst;
    end
    for (int k = 0; k < 62; k++) send_graph_op(OP_CONNECT, chain_src[k], chain_dst[k]);
    send_graph_op(OP_CONNECT, 6'd2, 6'd0);
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    drain_block();
    // hold longer than the slowest possible query so results back up
    out_hold_cycles = 4500;
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    // keep offering while the results back up
    repeat (6) send_graph_op(OP_DISCONNECT, NODE_W'($urandom_range(40, 63)),
                             NODE_W'($urandom_range(0, 63)));
    send_graph_op(OP_QUERY, 6'd0, 6'd0);
    idle_on = 1'b1;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (out_hold_cycles != 0) begin
        stall = out_hold_cycles;
        out_hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    node_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (node_report_q.size() == 0) begin
        $display("%0t: unexpected transfer, got tdata %h tlast %b", $realtime, out_tdata,
                 out_tlast);
        error_count++;
      end else begin
        want = node_report_q.pop_front();
        reports_checked++;
        if (out_tdata[5:0] !== want.node) begin
          $display("%0t: node_index expected %0d got %0d", $realtime, want.node,
                   out_tdata[5:0]);
          error_count++;
        end
        if (out_tdata[6] !== want.energized) begin
          $display("%0t: node %0d energized expected %b got %b", $realtime, want.node,
                   want.energized, out_tdata[6]);
          error_count++;
        end
        if (out_tdata[13:7] !== want.sweeps) begin
          $display("%0t: node %0d sweep_count expected %0d got %0d", $realtime, want.node,
                   want.sweeps, out_tdata[13:7]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: node %0d tlast expected %b got %b", $realtime, want.node,
                   want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_on = 1'b1;
    out_hold_cycles = 0;
    error_count = 0;
    items_sent = 0;
    queries_sent = 0;
    reports_checked = 0;
    deepest_sweeps = 0;
    node_count_model = COUNT_W'(NODES);
    for (int i = 0; i < NODES; i++) edge_rows[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_edges();
    test_node_count_limits();
    test_random_graphs();
    test_descending_chain();
    test_output_backpressure();

    drain_block();
    repeat (20) @(posedge clk);
    $display("Sent %0d items with %0d queries at node counts from 2 to 64.", items_sent,
             queries_sent);
    $display("Checked %0d node reports; deepest query took %0d sweeps.", reports_checked,
             deepest_sweeps);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
